/* hdl/rlqt_pkg.sv */
// Package for the radio link quality tally: widths, codes, control types and
// small helpers shared by the interfaces, controller, divider and datapath.
// Depends on nothing.
`timescale 1ns / 1ps

package rlqt_pkg;

    localparam int COUNT_BITS  = 16;
    localparam int RTT_W       = 32;
    localparam int RTT_TOTAL_W = 48;
    localparam int SUM_W       = 24;
    localparam int BYTE_W      = 8;
    localparam int PCT_W       = 7;
    localparam int CMD_W       = 2;
    localparam int ECHO_OUT_W  = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;

    localparam int LOSS_DVD_W  = COUNT_BITS + 8;
    localparam int SHORT_W     = (LOSS_DVD_W > SUM_W) ? LOSS_DVD_W : SUM_W;
    localparam int STEP_W      = $clog2(RTT_TOTAL_W + 1);

    localparam logic [COUNT_BITS-1:0]  CNT_MAX       = {COUNT_BITS{1'b1}};
    localparam logic [RTT_TOTAL_W-1:0] RTT_TOTAL_MAX = {RTT_TOTAL_W{1'b1}};
    localparam logic [RTT_W-1:0]       RTT_ALL_ONES  = {RTT_W{1'b1}};
    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic [PCT_W-1:0]       PCT_FULL      = 7'd100;
    localparam logic signed [BYTE_W-1:0] AVG_POS_MAX = 8'sd127;
    localparam logic signed [BYTE_W-1:0] AVG_NEG_MIN = -8'sd128;

    localparam logic [PCT_W-1:0]  LOSS_MARGINAL_RST = 7'd20;
    localparam logic [PCT_W-1:0]  LOSS_USABLE_RST   = 7'd5;
    localparam logic signed [BYTE_W-1:0] SNR_MARGINAL_RST = -8'sd20;
    localparam logic signed [BYTE_W-1:0] SNR_GOOD_RST     = 8'sd20;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR = 2'd0,
        CMD_PROBE = 2'd1,
        CMD_ECHO  = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        VERDICT_NO_LINK  = 2'd0,
        VERDICT_MARGINAL = 2'd1,
        VERDICT_USABLE   = 2'd2,
        VERDICT_GOOD     = 2'd3
    } t_verdict;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOSS_MARGINAL = 2'd0,
        CFG_LOSS_USABLE   = 2'd1,
        CFG_SNR_MARGINAL  = 2'd2,
        CFG_SNR_GOOD      = 2'd3
    } t_cfg_reg;

    typedef enum logic [2:0] {
        OP_LOSS   = 3'd0,
        OP_RTT    = 3'd1,
        OP_RSSI_L = 3'd2,
        OP_RSSI_R = 3'd3,
        OP_SNR_L  = 3'd4,
        OP_SNR_R  = 3'd5
    } t_div_op;

    typedef enum logic [2:0] {
        S_IDLE   = 3'd0,
        S_UPDATE = 3'd1,
        S_LOAD   = 3'd2,
        S_RUN    = 3'd3,
        S_STORE  = 3'd4,
        S_EMIT   = 3'd5
    } t_state;

    typedef struct packed {
        logic    capture;
        logic    update;
        logic    div_load;
        logic    div_step;
        logic    div_store;
        logic    emit;
        t_div_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_sts;

    typedef struct packed {
        logic [CMD_W-1:0]         cmd;
        logic [RTT_W-1:0]         rtt_ms;
        logic signed [BYTE_W-1:0] rssi_local;
        logic signed [BYTE_W-1:0] snr_local_q;
        logic signed [BYTE_W-1:0] rssi_remote;
        logic signed [BYTE_W-1:0] snr_remote_q;
    } t_in_item;

    function automatic logic [STEP_W-1:0] div_steps(input t_div_op op);
        logic [STEP_W-1:0] steps;
        if (op == OP_RTT) begin
            steps = STEP_W'(RTT_TOTAL_W);
        end else begin
            steps = STEP_W'(SHORT_W);
        end
        return steps;
    endfunction

endpackage

/* hdl/rlqt_if.sv */
// Valid/ready channel interfaces of the link quality tally: input events,
// result beats and configuration writes. Depends on rlqt_pkg.
`timescale 1ns / 1ps

interface rlqt_in_if import rlqt_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         cmd;
    logic [RTT_W-1:0]         rtt_ms;
    logic signed [BYTE_W-1:0] rssi_local;
    logic signed [BYTE_W-1:0] snr_local_q;
    logic signed [BYTE_W-1:0] rssi_remote;
    logic signed [BYTE_W-1:0] snr_remote_q;

    modport source (output valid, cmd, rtt_ms, rssi_local, snr_local_q, rssi_remote,
                    snr_remote_q, input ready);
    modport sink (input valid, cmd, rtt_ms, rssi_local, snr_local_q, rssi_remote,
                  snr_remote_q, output ready);
endinterface

interface rlqt_out_if import rlqt_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [ECHO_OUT_W-1:0]    echo_count;
    logic [PCT_W-1:0]         loss_pct;
    logic [1:0]               verdict;
    logic [RTT_W-1:0]         rtt_min;
    logic [RTT_W-1:0]         rtt_avg;
    logic [RTT_W-1:0]         rtt_max;
    logic signed [BYTE_W-1:0] rssi_local_avg;
    logic signed [BYTE_W-1:0] rssi_local_worst;
    logic signed [BYTE_W-1:0] rssi_remote_avg;
    logic signed [BYTE_W-1:0] rssi_remote_worst;
    logic signed [BYTE_W-1:0] snr_local_avg_q;
    logic signed [BYTE_W-1:0] snr_remote_avg_q;

    modport source (output valid, echo_count, loss_pct, verdict, rtt_min, rtt_avg, rtt_max,
                    rssi_local_avg, rssi_local_worst, rssi_remote_avg, rssi_remote_worst,
                    snr_local_avg_q, snr_remote_avg_q, input ready);
    modport sink (input valid, echo_count, loss_pct, verdict, rtt_min, rtt_avg, rtt_max,
                  rssi_local_avg, rssi_local_worst, rssi_remote_avg, rssi_remote_worst,
                  snr_local_avg_q, snr_remote_avg_q, output ready);
endinterface

interface rlqt_cfg_if import rlqt_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] wdata;

    modport source (output valid, reg_index, wdata, input ready);
    modport sink (input valid, reg_index, wdata, output ready);
endinterface

/* hdl/rlqt_ctrl.sv */
// Controller of the link quality tally: sequences the tally update, the six
// divisions on the shared divider and the result beat. Depends on rlqt_pkg.
`timescale 1ns / 1ps

module rlqt_ctrl import rlqt_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state            r_state, n_state;
    t_div_op           r_op, n_op;
    logic [STEP_W-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_LOSS;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_cnt   = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                n_state = S_LOAD;
                n_op    = OP_LOSS;
            end
            S_LOAD: begin
                n_state = S_RUN;
                n_cnt   = div_steps(r_op);
            end
            S_RUN: begin
                n_cnt = r_cnt - STEP_W'(1);
                if (r_cnt == STEP_W'(1)) begin
                    n_state = S_STORE;
                end
            end
            S_STORE: begin
                if (r_op == OP_SNR_R) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_LOAD;
                    n_op    = t_div_op'(r_op + 3'd1);
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.op   = r_op;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
            end
            S_LOAD: begin
                o_cmd.div_load = 1'b1;
            end
            S_RUN: begin
                o_cmd.div_step = 1'b1;
            end
            S_STORE: begin
                o_cmd.div_store = 1'b1;
            end
            S_EMIT: begin
                o_cmd.emit = i_sts.out_free;
            end
            default: begin
                o_cmd.update = 1'b0;
            end
        endcase
    end

endmodule

/* hdl/rlqt_div.sv */
// Shared restoring divider of the link quality tally, one quotient bit per
// cycle while i_step is high, over a left-aligned dividend. Depends on rlqt_pkg.
`timescale 1ns / 1ps

module rlqt_div import rlqt_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_load,
    input  logic                   i_step,
    input  logic [RTT_TOTAL_W-1:0] i_dividend,
    input  logic [COUNT_BITS-1:0]  i_divisor,
    output logic [RTT_TOTAL_W-1:0] o_quotient
);

    logic [RTT_TOTAL_W-1:0] r_quo;
    logic [COUNT_BITS-1:0]  r_rem;
    logic [COUNT_BITS-1:0]  r_dsr;
    logic [COUNT_BITS:0]    rem_sh;
    logic                   ge;

    assign rem_sh = {r_rem, r_quo[RTT_TOTAL_W-1]};
    assign ge     = rem_sh >= {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (i_step) begin
            r_quo <= {r_quo[RTT_TOTAL_W-2:0], ge};
            r_rem <= ge ? COUNT_BITS'(rem_sh - {1'b0, r_dsr}) : COUNT_BITS'(rem_sh);
        end
    end

    assign o_quotient = r_quo;

endmodule

/* hdl/rlqt_dp.sv */
// Datapath of the link quality tally: threshold registers, tallies, divider
// operand selection, averages, verdict and the result register.
// Depends on rlqt_pkg, rlqt_if and rlqt_div.
`timescale 1ns / 1ps

module rlqt_dp import rlqt_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_in_item         i_item,
    input  t_dp_cmd          i_cmd,
    output t_dp_sts          o_sts,
    rlqt_cfg_if.sink         i_cfg,
    rlqt_out_if.source       o_out
);

    function automatic logic signed [SUM_W-1:0] sat_add(
        input logic signed [SUM_W-1:0]  total,
        input logic signed [BYTE_W-1:0] x
    );
        logic signed [SUM_W:0] s;
        logic signed [SUM_W-1:0] r;
        s = {total[SUM_W-1], total} + (SUM_W+1)'(x);
        if (s > (SUM_W+1)'(SUM_MAX)) begin
            r = SUM_MAX;
        end else if (s < (SUM_W+1)'(SUM_MIN)) begin
            r = SUM_MIN;
        end else begin
            r = SUM_W'(s);
        end
        return r;
    endfunction

    logic [PCT_W-1:0]         r_loss_marg, r_loss_usable;
    logic signed [BYTE_W-1:0] r_snr_marg, r_snr_good;

    t_in_item                 r_item;

    logic [COUNT_BITS-1:0]    r_probes, r_echoes;
    logic [RTT_TOTAL_W-1:0]   r_rtt_total;
    logic [RTT_W-1:0]         r_rtt_low, r_rtt_high;
    logic signed [SUM_W-1:0]  r_rl_sum, r_rr_sum, r_sl_sum, r_sr_sum;
    logic signed [BYTE_W-1:0] r_rl_low, r_rr_low;

    logic [PCT_W-1:0]         r_loss;
    logic [RTT_W-1:0]         r_rtt_avg;
    logic signed [BYTE_W-1:0] r_rl_avg, r_rr_avg, r_sl_avg, r_sr_avg;

    logic                     r_out_valid;

    logic [RTT_TOTAL_W:0]     rtt_add;
    logic [COUNT_BITS-1:0]    lost;
    logic [LOSS_DVD_W-1:0]    loss_dvd;
    logic signed [SUM_W-1:0]  sel_sum;
    logic                     sel_neg;
    logic [SUM_W-1:0]         sel_abs;
    logic [SHORT_W-1:0]       short_dvd;
    logic [RTT_TOTAL_W-1:0]   dividend;
    logic [COUNT_BITS-1:0]    divisor;
    logic [RTT_TOTAL_W-1:0]   quotient;
    logic [SHORT_W-1:0]       mag;
    logic signed [BYTE_W-1:0] avg_val;
    logic signed [BYTE_W-1:0] snr_worse;
    t_verdict                 verdict;
    logic                     no_echo;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loss_marg   <= LOSS_MARGINAL_RST;
            r_loss_usable <= LOSS_USABLE_RST;
            r_snr_marg    <= SNR_MARGINAL_RST;
            r_snr_good    <= SNR_GOOD_RST;
        end else if (i_cfg.valid) begin
            case (t_cfg_reg'(i_cfg.reg_index))
                CFG_LOSS_MARGINAL: r_loss_marg   <= PCT_W'(i_cfg.wdata);
                CFG_LOSS_USABLE:   r_loss_usable <= PCT_W'(i_cfg.wdata);
                CFG_SNR_MARGINAL:  r_snr_marg    <= i_cfg.wdata;
                CFG_SNR_GOOD:      r_snr_good    <= i_cfg.wdata;
                default:           r_snr_good    <= r_snr_good;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_item;
        end
    end

    assign no_echo = (r_echoes == '0);
    assign rtt_add = {1'b0, r_rtt_total} + (RTT_TOTAL_W+1)'(r_item.rtt_ms);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probes    <= '0;
            r_echoes    <= '0;
            r_rtt_total <= '0;
            r_rtt_low   <= RTT_ALL_ONES;
            r_rtt_high  <= '0;
            r_rl_sum    <= '0;
            r_rr_sum    <= '0;
            r_sl_sum    <= '0;
            r_sr_sum    <= '0;
            r_rl_low    <= '0;
            r_rr_low    <= '0;
        end else if (i_cmd.update) begin
            case (t_cmd'(r_item.cmd))
                CMD_CLEAR: begin
                    r_probes    <= '0;
                    r_echoes    <= '0;
                    r_rtt_total <= '0;
                    r_rtt_low   <= RTT_ALL_ONES;
                    r_rtt_high  <= '0;
                    r_rl_sum    <= '0;
                    r_rr_sum    <= '0;
                    r_sl_sum    <= '0;
                    r_sr_sum    <= '0;
                    r_rl_low    <= '0;
                    r_rr_low    <= '0;
                end
                CMD_PROBE: begin
                    if (r_probes != CNT_MAX) begin
                        r_probes <= r_probes + COUNT_BITS'(1);
                    end
                end
                CMD_ECHO: begin
                    if (r_echoes != CNT_MAX) begin
                        r_echoes    <= r_echoes + COUNT_BITS'(1);
                        r_rtt_total <= rtt_add[RTT_TOTAL_W] ? RTT_TOTAL_MAX
                                                            : rtt_add[RTT_TOTAL_W-1:0];
                        if (r_item.rtt_ms < r_rtt_low) begin
                            r_rtt_low <= r_item.rtt_ms;
                        end
                        if (r_item.rtt_ms > r_rtt_high) begin
                            r_rtt_high <= r_item.rtt_ms;
                        end
                        r_rl_sum <= sat_add(r_rl_sum, r_item.rssi_local);
                        r_rr_sum <= sat_add(r_rr_sum, r_item.rssi_remote);
                        r_sl_sum <= sat_add(r_sl_sum, r_item.snr_local_q);
                        r_sr_sum <= sat_add(r_sr_sum, r_item.snr_remote_q);
                        if (no_echo || r_item.rssi_local < r_rl_low) begin
                            r_rl_low <= r_item.rssi_local;
                        end
                        if (no_echo || r_item.rssi_remote < r_rr_low) begin
                            r_rr_low <= r_item.rssi_remote;
                        end
                    end
                end
                default: begin
                    r_probes <= r_probes;
                end
            endcase
        end
    end

    assign lost     = (r_probes > r_echoes) ? (r_probes - r_echoes) : '0;
    assign loss_dvd = LOSS_DVD_W'(lost) * LOSS_DVD_W'(PCT_FULL)
                    + LOSS_DVD_W'(r_probes >> 1);

    always_comb begin
        case (i_cmd.op)
            OP_RSSI_L: sel_sum = r_rl_sum;
            OP_RSSI_R: sel_sum = r_rr_sum;
            OP_SNR_L:  sel_sum = r_sl_sum;
            OP_SNR_R:  sel_sum = r_sr_sum;
            default:   sel_sum = '0;
        endcase
    end

    assign sel_neg = sel_sum[SUM_W-1];
    assign sel_abs = sel_neg ? SUM_W'(-sel_sum) : SUM_W'(sel_sum);

    always_comb begin
        short_dvd = SHORT_W'(sel_abs);
        divisor   = r_echoes;
        dividend  = {short_dvd, {(RTT_TOTAL_W-SHORT_W){1'b0}}};
        case (i_cmd.op)
            OP_LOSS: begin
                short_dvd = SHORT_W'(loss_dvd);
                divisor   = r_probes;
                dividend  = {short_dvd, {(RTT_TOTAL_W-SHORT_W){1'b0}}};
            end
            OP_RTT: begin
                dividend = r_rtt_total;
            end
            default: begin
                divisor = r_echoes;
            end
        endcase
    end

    rlqt_div u_div (
        .i_clk      (i_clk),
        .i_load     (i_cmd.div_load),
        .i_step     (i_cmd.div_step),
        .i_dividend (dividend),
        .i_divisor  (divisor),
        .o_quotient (quotient)
    );

    assign mag = quotient[SHORT_W-1:0];

    always_comb begin
        if (no_echo) begin
            avg_val = '0;
        end else if (sel_neg) begin
            if (mag > SHORT_W'(-AVG_NEG_MIN)) begin
                avg_val = AVG_NEG_MIN;
            end else begin
                avg_val = BYTE_W'(-(mag[BYTE_W:0]));
            end
        end else if (mag > SHORT_W'(AVG_POS_MAX)) begin
            avg_val = AVG_POS_MAX;
        end else begin
            avg_val = BYTE_W'(mag);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_store) begin
            case (i_cmd.op)
                OP_LOSS:   r_loss    <= (r_probes == '0) ? PCT_FULL : PCT_W'(quotient);
                OP_RTT:    r_rtt_avg <= no_echo ? '0 : RTT_W'(quotient);
                OP_RSSI_L: r_rl_avg  <= avg_val;
                OP_RSSI_R: r_rr_avg  <= avg_val;
                OP_SNR_L:  r_sl_avg  <= avg_val;
                OP_SNR_R:  r_sr_avg  <= avg_val;
                default:   r_loss    <= r_loss;
            endcase
        end
    end

    assign snr_worse = (r_sl_avg < r_sr_avg) ? r_sl_avg : r_sr_avg;

    always_comb begin
        if (no_echo) begin
            verdict = VERDICT_NO_LINK;
        end else if (r_loss > r_loss_marg || snr_worse < r_snr_marg) begin
            verdict = VERDICT_MARGINAL;
        end else if (r_loss > r_loss_usable || snr_worse < r_snr_good) begin
            verdict = VERDICT_USABLE;
        end else begin
            verdict = VERDICT_GOOD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_out.echo_count        <= ECHO_OUT_W'(r_echoes);
            o_out.loss_pct          <= r_loss;
            o_out.verdict           <= verdict;
            o_out.rtt_min           <= r_rtt_low;
            o_out.rtt_avg           <= r_rtt_avg;
            o_out.rtt_max           <= r_rtt_high;
            o_out.rssi_local_avg    <= r_rl_avg;
            o_out.rssi_local_worst  <= r_rl_low;
            o_out.rssi_remote_avg   <= r_rr_avg;
            o_out.rssi_remote_worst <= r_rr_low;
            o_out.snr_local_avg_q   <= r_sl_avg;
            o_out.snr_remote_avg_q  <= r_sr_avg;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_sts.out_free = !r_out_valid || o_out.ready;

endmodule

/* hdl/radio_link_quality_tally_core.sv */
// Radio link quality tally, top level. Joins the controller and the datapath.
// Depends on rlqt_pkg, rlqt_if, rlqt_ctrl and rlqt_dp.
//
// The i_in channel takes one event beat at a time: clear, probe sent, or
// echo received with its round-trip time, RSSI and quarter-dB SNR. Every
// accepted beat yields exactly one result beat on o_out carrying the echo
// count, rounded loss percentage, RTT minimum, average and maximum, the
// RSSI and SNR averages, the worst RSSI values and the link verdict.
// The i_cfg channel writes the four verdict thresholds and is always ready;
// write it only while no event is in progress.
// After acceptance an event passes through one tally update, then six
// divisions on the single shared bit-serial divider (the RTT average takes
// 48 steps, the loss and the four signed averages 24 each), each with a
// load state before its steps and a store state after them, and at last
// the result register is loaded. The next event is accepted in the cycle
// after the result is loaded, so no event is taken while one is in progress.
// If o_out stalls, the next event is still accepted and processed; its
// result waits until the held beat has been taken.
// Synchronous reset restores the default thresholds and clears all tallies.
`timescale 1ns / 1ps

module radio_link_quality_tally_core import rlqt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rlqt_in_if.sink     i_in,
    rlqt_out_if.source  o_out,
    rlqt_cfg_if.sink    i_cfg
);

    t_dp_cmd  dp_cmd;
    t_dp_sts  dp_sts;
    t_in_item item;
    logic     in_ready;

    assign item.cmd          = i_in.cmd;
    assign item.rtt_ms       = i_in.rtt_ms;
    assign item.rssi_local   = i_in.rssi_local;
    assign item.snr_local_q  = i_in.snr_local_q;
    assign item.rssi_remote  = i_in.rssi_remote;
    assign item.snr_remote_q = i_in.snr_remote_q;
    assign i_in.ready        = in_ready;

    rlqt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    rlqt_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item),
        .i_cmd   (dp_cmd),
        .o_sts   (dp_sts),
        .i_cfg   (i_cfg),
        .o_out   (o_out)
    );

endmodule
